// ===== rtl/fcst_pkg.sv =====
`default_nettype none

package fcst_pkg;

  typedef logic [4:0] state_t;

  typedef struct packed {
    logic       mode;
    logic [9:0] flow_index;
    logic       is_response;
    logic [3:0] tcp_flags;
    state_t     set_state;
  } in_t;

  typedef struct packed {
    state_t prior_state;
    state_t updated_state;
    logic   hard_timeout;
    logic   known_entry;
  } out_t;

  // Event kinds carried in the mode field.
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_SET    = 1'b1;

  // Stored state codes that the logic tests by name.
  localparam state_t ST_ESTAB     = 5'd3;
  localparam state_t ST_TCP_LIMIT = 5'd10;
  localparam state_t ST_UDP_INIT  = 5'd13;
  localparam state_t ST_UDP_ESTAB = 5'd14;
  localparam state_t ST_NT_FIRST  = 5'd13;
  localparam state_t ST_NT_LIMIT  = 5'd17;

  // Flag patterns, bit3 SYN, bit2 ACK, bit1 FIN, bit0 RST.
  localparam logic [3:0] FLAGS_SYN     = 4'h8;
  localparam logic [3:0] FLAGS_SYN_ACK = 4'hC;
  localparam logic [3:0] FLAGS_FIN     = 4'h2;
  localparam logic [3:0] FLAGS_FIN_ACK = 4'h6;
  localparam logic [3:0] FLAGS_ACK     = 4'h4;
  localparam logic [3:0] FLAGS_RST     = 4'h1;
  localparam logic [3:0] FLAGS_RST_ACK = 4'h5;
  localparam logic [3:0] FLAGS_NONE    = 4'h0;

  // Rows of the TCP transition table.
  localparam logic [2:0] PAT_SYN     = 3'd0;
  localparam logic [2:0] PAT_SYN_ACK = 3'd1;
  localparam logic [2:0] PAT_FIN     = 3'd2;
  localparam logic [2:0] PAT_FIN_ACK = 3'd3;
  localparam logic [2:0] PAT_ACK     = 3'd4;
  localparam logic [2:0] PAT_RST     = 3'd5;
  localparam logic [2:0] PAT_RST_ACK = 3'd6;
  localparam logic [2:0] PAT_NONE    = 3'd7;

  // Indexed by direction, pattern row and current TCP state.
  localparam state_t TCP_NEXT [2][8][10] = '{
    '{
      '{5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd1, 5'd1, 5'd9},
      '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd10, 5'd7, 5'd8, 5'd2},
      '{5'd0, 5'd1, 5'd4, 5'd4, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9},
      '{5'd0, 5'd1, 5'd4, 5'd4, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9},
      '{5'd3, 5'd1, 5'd3, 5'd3, 5'd5, 5'd5, 5'd7, 5'd7, 5'd8, 5'd9},
      '{5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8},
      '{5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8},
      '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9}
    },
    '{
      '{5'd0, 5'd9, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd1, 5'd8, 5'd9},
      '{5'd0, 5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd2},
      '{5'd0, 5'd1, 5'd4, 5'd4, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9},
      '{5'd0, 5'd1, 5'd4, 5'd4, 5'd6, 5'd6, 5'd6, 5'd7, 5'd8, 5'd9},
      '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd5, 5'd7, 5'd7, 5'd8, 5'd9},
      '{5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8},
      '{5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8},
      '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9}
    }
  };

  // Indexed by direction and the state's offset from the first UDP state.
  localparam state_t NONTCP_NEXT [2][4] = '{
    '{5'd13, 5'd14, 5'd15, 5'd16},
    '{5'd14, 5'd14, 5'd16, 5'd16}
  };

endpackage

`default_nettype wire

// ===== rtl/flow_connection_state_tracker.sv =====
`default_nettype none
// Channel    Handshake                 Payload               Direction
// command    start, busy               item   (in_t)         into the block
// result     result_valid (strobe)     result (out_t)        out of the block
//
// One transaction is taken in every cycle while busy is low; its result is
// driven from the edge after acceptance for exactly one cycle and is taken at
// the edge after that.
// The latency is set by the registered read of the state memory followed by
// the transition logic and the result register.
// After reset, busy stays high while a clearing pass writes state none
// into every flow entry, one entry a cycle.
// The result side cannot stall, so busy is high only in reset and that pass.

module flow_connection_state_tracker #(
  parameter int FLOW_COUNT = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire fcst_pkg::in_t  item,
  output logic                result_valid,
  output fcst_pkg::out_t      result
);

  import fcst_pkg::*;

  localparam int AW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;

  // Clearing pass over the state memory.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Stage one: the transaction whose old state is being read out of memory.
  logic          s1_valid;
  in_t           s1_item;
  logic          s1_in_range;

  // Bypass for back-to-back transactions on the same flow: the memory read
  // of the second one happens at the edge that writes the first one's state.
  logic          fwd_hit;
  state_t        fwd_state;

  logic          accept;
  logic          in_range;
  state_t        ram_rdata;
  state_t        old_st;
  out_t          res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  state_t        ram_wdata;

  assign busy     = clearing || rst;
  assign accept   = start && !busy;
  assign in_range = 32'(item.flow_index) < 32'(FLOW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(FLOW_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fwd_hit      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= accept;
      fwd_hit      <= accept && s1_valid && s1_in_range &&
                      (item.flow_index == s1_item.flow_index);
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item     <= item;
    s1_in_range <= in_range;
    fwd_state   <= res.updated_state;
    // An index beyond the store gives an all-zero result.
    result      <= s1_in_range ? res : '0;
  end

  // The clearing pass owns the write port; no transaction is in flight then.
  assign ram_we    = clearing || (s1_valid && s1_in_range);
  assign ram_waddr = clearing ? clr_addr : AW'(s1_item.flow_index);
  assign ram_wdata = clearing ? state_t'(0) : res.updated_state;

  fcst_ram #(
    .WIDTH ($bits(state_t)),
    .DEPTH (FLOW_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(item.flow_index)),
    .rdata (ram_rdata)
  );

  assign old_st = fwd_hit ? fwd_state : ram_rdata;

  fcst_next u_next (
    .item      (s1_item),
    .cur_state (old_st),
    .res       (res)
  );

  // No transaction can be in flight while the memory is being cleared.
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s1_valid)
    else $error("transaction in flight during clearing pass");

  // A bypass only ever serves a transaction that sits in stage one.
  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("bypass hit without a transaction in stage one");

  // An out-of-range flow index yields an all-zero result.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_in_range) |=> (result_valid && (result == '0)))
    else $error("out-of-range transaction gave a nonzero result");

  // A state change never comes with a hard timeout.
  a_change_no_hard: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.updated_state != result.prior_state)) |->
      !result.hard_timeout)
    else $error("hard timeout set on a state change");

endmodule

`default_nettype wire

// ===== rtl/fcst_ram.sv =====
`default_nettype none

module fcst_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/fcst_next.sv =====
`default_nettype none

module fcst_next (
  input  wire fcst_pkg::in_t    item,
  input  wire fcst_pkg::state_t cur_state,
  output fcst_pkg::out_t        res
);

  import fcst_pkg::*;

  logic [2:0] pat;
  logic       pat_ok;
  logic [1:0] nt_offset;
  state_t     next_st;
  logic       known;
  logic       hard;

  always_comb begin
    pat    = PAT_NONE;
    pat_ok = 1'b1;
    unique case (item.tcp_flags)
      FLAGS_SYN:     pat = PAT_SYN;
      FLAGS_SYN_ACK: pat = PAT_SYN_ACK;
      FLAGS_FIN:     pat = PAT_FIN;
      FLAGS_FIN_ACK: pat = PAT_FIN_ACK;
      FLAGS_ACK:     pat = PAT_ACK;
      FLAGS_RST:     pat = PAT_RST;
      FLAGS_RST_ACK: pat = PAT_RST_ACK;
      FLAGS_NONE:    pat = PAT_NONE;
      default:       pat_ok = 1'b0;
    endcase
  end

  assign nt_offset = 2'(cur_state - ST_NT_FIRST);

  always_comb begin
    next_st = cur_state;
    known   = 1'b0;
    hard    = 1'b0;
    if (item.mode == MODE_SET) begin
      next_st = item.set_state;
    end else begin
      if ((cur_state < ST_TCP_LIMIT) && pat_ok) begin
        next_st = TCP_NEXT[item.is_response][pat][cur_state[3:0]];
        known   = 1'b1;
      end else if ((cur_state >= ST_NT_FIRST) && (cur_state < ST_NT_LIMIT) &&
                   (item.tcp_flags == FLAGS_NONE)) begin
        next_st = NONTCP_NEXT[item.is_response][nt_offset];
        known   = 1'b1;
      end
      // Established and UDP states always refresh on idle.
      if ((next_st == ST_ESTAB) || (next_st == ST_UDP_INIT) || (next_st == ST_UDP_ESTAB)) begin
        hard = 1'b0;
      end else begin
        hard = (next_st == cur_state);
      end
    end
  end

  assign res = '{prior_state: cur_state, updated_state: next_st,
                 hard_timeout: hard, known_entry: known};

endmodule

`default_nettype wire

// ===== tb/tb_flow_connection_state_tracker.sv =====
`timescale 1ns / 100ps

module tb_flow_connection_state_tracker;
  import fcst_pkg::*;

  localparam int FLOW_COUNT = 1024;

  // A slow but correct run never goes this long without a transaction.
  // The limit stays well above the clearing pass after reset and the longest
  // sender gap or drain pause.
  localparam int unsigned STALL_LIMIT = 5 * FLOW_COUNT;
  // Results come back from a registered pipeline; this covers stray late ones.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned RANDOM_CMDS = 1050;
  localparam int unsigned PAUSE_EVERY = 350;

  localparam logic       DIR_REQ   = 1'b0;
  localparam logic       DIR_RSP   = 1'b1;
  localparam logic [3:0] FLAGS_ALL = 4'hF;
  localparam logic [9:0] FLOW_LAST = 10'(FLOW_COUNT - 1);

  // State codes used by the directed transactions that the package does not name.
  localparam state_t ST_NONE      = 5'd0;
  localparam state_t ST_SYN_SENT  = 5'd1;
  localparam state_t ST_UNUSED    = 5'd11;
  localparam state_t ST_ICMP_INIT = 5'd15;
  localparam state_t ST_TOP_CODE  = 5'd31;

  // The eight flag patterns that the TCP tables are programmed for.
  localparam logic [3:0] TCP_FLAGS [8] = '{FLAGS_SYN, FLAGS_SYN_ACK, FLAGS_FIN,
                                           FLAGS_FIN_ACK, FLAGS_ACK, FLAGS_RST,
                                           FLAGS_RST_ACK, FLAGS_NONE};

  // A textbook connection: three-way handshake, data in both directions,
  // then an orderly close from the requesting side.
  localparam logic [3:0] OPEN_CLOSE_FLAGS [9] = '{FLAGS_SYN, FLAGS_SYN_ACK, FLAGS_ACK,
                                                  FLAGS_ACK, FLAGS_ACK, FLAGS_FIN_ACK,
                                                  FLAGS_ACK, FLAGS_FIN_ACK, FLAGS_ACK};
  localparam logic       OPEN_CLOSE_DIR   [9] = '{DIR_REQ, DIR_RSP, DIR_REQ,
                                                  DIR_RSP, DIR_REQ, DIR_REQ,
                                                  DIR_RSP, DIR_RSP, DIR_REQ};

  // Next TCP state, indexed by direction, flag pattern row and current state.
  // Rows: SYN, SYN+ACK, FIN, FIN+ACK, ACK, RST, RST+ACK, no flags.
  localparam int TCP_STEP [2][8][10] = '{
    '{
      '{1, 1, 2, 3, 4, 5, 6, 1, 1, 9},
      '{0, 1, 2, 3, 4, 5, 10, 7, 8, 2},
      '{0, 1, 4, 4, 6, 6, 6, 7, 8, 9},
      '{0, 1, 4, 4, 6, 6, 6, 7, 8, 9},
      '{3, 1, 3, 3, 5, 5, 7, 7, 8, 9},
      '{0, 8, 8, 8, 8, 8, 8, 8, 8, 8},
      '{0, 8, 8, 8, 8, 8, 8, 8, 8, 8},
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9}
    },
    '{
      '{0, 9, 2, 3, 4, 5, 6, 1, 8, 9},
      '{0, 2, 2, 3, 4, 5, 6, 7, 8, 2},
      '{0, 1, 4, 4, 6, 6, 6, 7, 8, 9},
      '{0, 1, 4, 4, 6, 6, 6, 7, 8, 9},
      '{0, 1, 2, 3, 5, 5, 7, 7, 8, 9},
      '{0, 8, 8, 8, 8, 8, 8, 8, 8, 8},
      '{0, 8, 8, 8, 8, 8, 8, 8, 8, 8},
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9}
    }
  };

  // Next UDP/ICMP state, indexed by direction and offset from the UDP init state.
  localparam int NONTCP_STEP [2][4] = '{'{13, 14, 15, 16}, '{14, 14, 16, 16}};

  typedef struct {
    in_t cmd;
    bit  wait_idle;   // hold this transaction back until every result is in
  } pending_cmd_t;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic start        = 1'b0;
  in_t  item         = '0;
  logic busy;
  logic result_valid;
  out_t result;

  // A command transaction completes at any rising edge where start is high
  // and busy is low. Busy may be unknown right after reset; treat that as busy.
  wire take = start && (busy === 1'b0);

  pending_cmd_t cmd_q [$];
  out_t         flow_result_q [$];
  state_t       conn_state_mirror [FLOW_COUNT];
  logic [9:0]   flow_pool [8];

  int unsigned total_cmds;
  int unsigned sent_cnt;
  int unsigned done_cnt;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned set_cnt;
  int unsigned known_cnt;
  int unsigned held_cnt;

  flow_connection_state_tracker #(
    .FLOW_COUNT(FLOW_COUNT)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .result_valid(result_valid),
    .result      (result)
  );

  always #5 clk = ~clk;

  // Computes what the tracker must report for one event given the flow's
  // current state. The caller writes the new state back into its mirror.
  function automatic out_t track_flow_event(input in_t ev, input state_t cur);
    out_t       r;
    logic [2:0] row;
    bit         row_ok;
    r = '0;
    if (ev.flow_index >= FLOW_COUNT) begin
      return r;
    end
    r.prior_state   = cur;
    r.updated_state = cur;
    if (ev.mode == MODE_SET) begin
      r.updated_state = ev.set_state;
      return r;
    end
    row_ok = 1'b1;
    case (ev.tcp_flags)
      FLAGS_SYN:     row = PAT_SYN;
      FLAGS_SYN_ACK: row = PAT_SYN_ACK;
      FLAGS_FIN:     row = PAT_FIN;
      FLAGS_FIN_ACK: row = PAT_FIN_ACK;
      FLAGS_ACK:     row = PAT_ACK;
      FLAGS_RST:     row = PAT_RST;
      FLAGS_RST_ACK: row = PAT_RST_ACK;
      FLAGS_NONE:    row = PAT_NONE;
      default: begin
        row    = PAT_NONE;
        row_ok = 1'b0;
      end
    endcase
    if (cur < ST_TCP_LIMIT && row_ok) begin
      r.updated_state = state_t'(TCP_STEP[ev.is_response][row][cur]);
      r.known_entry   = 1'b1;
    end else if (cur >= ST_NT_FIRST && cur < ST_NT_LIMIT && ev.tcp_flags == FLAGS_NONE) begin
      r.updated_state = state_t'(NONTCP_STEP[ev.is_response][cur - ST_NT_FIRST]);
      r.known_entry   = 1'b1;
    end
    // Established TCP and both UDP states always run on an idle timeout;
    // anything else gets a hard timeout only when the state did not move.
    if (r.updated_state == ST_ESTAB || r.updated_state == ST_UDP_INIT ||
        r.updated_state == ST_UDP_ESTAB) begin
      r.hard_timeout = 1'b0;
    end else begin
      r.hard_timeout = (r.updated_state == r.prior_state);
    end
    return r;
  endfunction

  task automatic add_cmd(input logic mode, input logic [9:0] flow, input logic dir,
                         input logic [3:0] flags, input state_t st, input bit wait_idle);
    pending_cmd_t p;
    p.cmd.mode        = mode;
    p.cmd.flow_index  = flow;
    p.cmd.is_response = dir;
    p.cmd.tcp_flags   = flags;
    p.cmd.set_state   = st;
    p.wait_idle       = wait_idle;
    cmd_q.push_back(p);
  endtask

  // Most traffic lands on a handful of flows so that their state walks deep
  // into the tables; the rest is scattered over the whole flow table.
  function automatic logic [9:0] pick_flow();
    if ($urandom_range(99) < 85) begin
      return flow_pool[$urandom_range(7)];
    end
    return 10'($urandom_range(FLOW_COUNT - 1));
  endfunction

  // Resets a flow to none and runs it through a full open and close. A few
  // steps get corrupted flags or a flipped direction to knock the flow off
  // the expected path.
  task automatic add_open_close(input logic [9:0] flow, input bit wait_idle);
    logic [3:0] flags;
    logic       dir;
    add_cmd(MODE_SET, flow, 1'($urandom_range(1)), 4'($urandom_range(15)), ST_NONE,
            wait_idle);
    for (int i = 0; i < 9; i++) begin
      flags = OPEN_CLOSE_FLAGS[i];
      dir   = OPEN_CLOSE_DIR[i];
      if ($urandom_range(99) < 10) begin
        flags = 4'($urandom_range(15));
      end
      if ($urandom_range(99) < 5) begin
        dir = ~dir;
      end
      add_cmd(MODE_PACKET, flow, dir, flags, 5'($urandom_range(31)), 1'b0);
    end
  endtask

  // A UDP or ICMP flow: start it, then send a few packets, nearly all flagless.
  task automatic add_datagram_flow(input logic [9:0] flow, input bit wait_idle);
    int unsigned n;
    n = $urandom_range(4, 2);
    add_cmd(MODE_SET, flow, 1'($urandom_range(1)), 4'($urandom_range(15)),
            $urandom_range(1) ? ST_UDP_INIT : ST_ICMP_INIT, wait_idle);
    for (int unsigned i = 0; i < n; i++) begin
      add_cmd(MODE_PACKET, flow, 1'($urandom_range(1)),
              ($urandom_range(99) < 20) ? 4'($urandom_range(15)) : FLAGS_NONE,
              5'($urandom_range(31)), 1'b0);
    end
  endtask

  // Driver. It puts the next pending transaction on the bus whenever the
  // bus is free, either holding start low for a random gap or, for a marked
  // transaction, until every result issued so far has come back. The counts
  // come from the pre-edge values of the handshake signals, so the decision
  // does not depend on the order of the clocked blocks.
  always @(posedge clk) begin
    int unsigned idle_pct;
    if (rst) begin
      start <= 1'b0;
      item  <= '0;
    end else begin
      if (take) begin
        sent_cnt++;
      end
      if (result_valid === 1'b1) begin
        done_cnt++;
      end
      // The sender idles 29 percent of the time in the first third of the
      // traffic, 62 percent in the second third, and never in the last.
      if (sent_cnt < total_cmds / 3) begin
        idle_pct = 29;
      end else if (sent_cnt < 2 * total_cmds / 3) begin
        idle_pct = 62;
      end else begin
        idle_pct = 0;
      end
      if (!start || take) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].wait_idle && sent_cnt != done_cnt) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
        end else begin
          item  <= cmd_q[0].cmd;
          start <= 1'b1;
          void'(cmd_q.pop_front());
        end
      end
    end
  end

  // Monitor. Every accepted command is run through the predictor and its
  // expected result queued; every result strobe is checked against the
  // oldest expectation, field by field. The latency is fixed, so the popped
  // expectation is always from an earlier transaction than the one pushed
  // in the same cycle.
  always @(posedge clk) begin : flow_result_check
    out_t want;
    if (!rst) begin
      if (result_valid === 1'b1) begin
        if (flow_result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] Unexpected result: old=%0d new=%0d hard=%0b known=%0b",
                     $time, result.prior_state, result.updated_state, result.hard_timeout,
                     result.known_entry);
          end
        end else begin
          want = flow_result_q.pop_front();
          if (result.prior_state !== want.prior_state ||
              result.updated_state !== want.updated_state ||
              result.hard_timeout !== want.hard_timeout ||
              result.known_entry !== want.known_entry) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] Result mismatch: expected old=%0d new=%0d hard=%0b known=%0b",
                       $time, want.prior_state, want.updated_state, want.hard_timeout,
                       want.known_entry);
              $display("[%0t]                  actual   old=%0d new=%0d hard=%0b known=%0b",
                       $time, result.prior_state, result.updated_state, result.hard_timeout,
                       result.known_entry);
            end
          end
        end
      end
      if (take) begin
        want = track_flow_event(item, conn_state_mirror[item.flow_index]);
        if (item.flow_index < FLOW_COUNT) begin
          conn_state_mirror[item.flow_index] = want.updated_state;
        end
        flow_result_q.push_back(want);
        if (item.mode == MODE_SET) begin
          set_cnt++;
        end else if (want.known_entry) begin
          known_cnt++;
        end else begin
          held_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction on either side completes for
  // too long.
  always @(posedge clk) begin
    if (rst || take || result_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned next_pause;
    bit          pause;
    int unsigned pick;

    foreach (conn_state_mirror[i]) begin
      conn_state_mirror[i] = ST_NONE;
    end
    flow_pool[0] = 10'd0;
    flow_pool[1] = FLOW_LAST;
    for (int i = 2; i < 8; i++) begin
      flow_pool[i] = 10'($urandom_range(FLOW_COUNT - 1));
    end

    // Directed part. Flow 0 goes through a full TCP life, including a
    // SYN+ACK in last_ack that lands in invalid and a packet in invalid
    // that holds. The last flow gets unprogrammed flags and the highest
    // code that a set can store. Then a UDP flow, an ICMP flow, and an
    // unused state code.
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_NONE, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_SYN, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_RSP, FLAGS_SYN_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_FIN, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_RSP, FLAGS_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_RSP, FLAGS_FIN_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_SYN_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_SET, 10'd0, DIR_REQ, FLAGS_NONE, ST_SYN_SENT, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_RSP, FLAGS_SYN, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd0, DIR_REQ, FLAGS_RST, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, FLOW_LAST, DIR_RSP, FLAGS_RST_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, FLOW_LAST, DIR_REQ, FLAGS_ALL, ST_TOP_CODE, 1'b0);
    add_cmd(MODE_SET, FLOW_LAST, DIR_RSP, FLAGS_ALL, ST_TOP_CODE, 1'b0);
    add_cmd(MODE_PACKET, FLOW_LAST, DIR_RSP, FLAGS_SYN, ST_NONE, 1'b0);
    add_cmd(MODE_SET, 10'd1, DIR_REQ, FLAGS_NONE, ST_UDP_INIT, 1'b0);
    add_cmd(MODE_PACKET, 10'd1, DIR_REQ, FLAGS_NONE, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd1, DIR_RSP, FLAGS_NONE, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd1, DIR_REQ, FLAGS_ACK, ST_NONE, 1'b0);
    add_cmd(MODE_SET, 10'd2, DIR_REQ, FLAGS_NONE, ST_ICMP_INIT, 1'b0);
    add_cmd(MODE_PACKET, 10'd2, DIR_RSP, FLAGS_NONE, ST_NONE, 1'b0);
    add_cmd(MODE_PACKET, 10'd2, DIR_REQ, FLAGS_NONE, ST_NONE, 1'b0);
    add_cmd(MODE_SET, 10'd3, DIR_REQ, FLAGS_NONE, ST_UNUSED, 1'b0);
    add_cmd(MODE_PACKET, 10'd3, DIR_RSP, FLAGS_NONE, ST_NONE, 1'b0);

    // Random part: mostly complete connections and datagram flows with
    // random content, the rest single events of any kind. Every few hundred
    // transactions the sender waits for the tracker to go fully idle; the
    // first such wait falls between the directed and the random traffic.
    next_pause = cmd_q.size();
    total_cmds = cmd_q.size() + RANDOM_CMDS;
    while (cmd_q.size() < total_cmds) begin
      pause = (cmd_q.size() >= next_pause);
      if (pause) begin
        next_pause += PAUSE_EVERY;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_open_close(pick_flow(), pause);
      end else if (pick < 40) begin
        add_datagram_flow(pick_flow(), pause);
      end else begin
        add_cmd(($urandom_range(9) == 0) ? MODE_SET : MODE_PACKET, pick_flow(),
                1'($urandom_range(1)),
                ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                         : TCP_FLAGS[$urandom_range(7)],
                5'($urandom_range(31)), pause);
      end
    end
    total_cmds = cmd_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every result to come back,
    // then a few more cycles to catch any result that should not be there.
    while (cmd_q.size() != 0 || start || flow_result_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (flow_result_q.size() != 0) begin
      $display("%0d expected results never arrived", flow_result_q.size());
      mismatches += flow_result_q.size();
    end
    $display("Ran %0d transactions on a %0d-flow table: %0d set events,", sent_cnt,
             FLOW_COUNT, set_cnt);
    $display("%0d programmed transitions and %0d held states; %0d mismatches", known_cnt,
             held_cnt, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
